// ===== hdl/icyst_pkg.sv =====
package icyst_pkg;

    localparam int MAX_BLOCK = 4096;
    localparam int ADDR_W    = $clog2(MAX_BLOCK);
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
    localparam int KEY_LEN   = 12;
    localparam int MATCH_W   = $clog2(KEY_LEN + 1);
    localparam int TITLE_W   = 13;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic
    {
        CMD_APPEND = 1'b0,
        CMD_READ   = 1'b1
    } command_t;

    typedef enum logic
    {
        KIND_SUMMARY = 1'b0,
        KIND_READ    = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        PH_KEY,
        PH_OPEN,
        PH_TITLE,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0]
    {
        CHK_IDLE,
        CHK_FIRST,
        CHK_WORD,
        CHK_EQ
    } check_t;

    typedef struct packed
    {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed
    {
        logic               found;
        logic [TITLE_W-1:0] start;
        logic [TITLE_W-1:0] length;
        logic               overflowed;
    } summary_t;

    function automatic logic [7:0] key_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            MATCH_W'(0):  c = 8'h53;
            MATCH_W'(1):  c = 8'h74;
            MATCH_W'(2):  c = 8'h72;
            MATCH_W'(3):  c = 8'h65;
            MATCH_W'(4):  c = 8'h61;
            MATCH_W'(5):  c = 8'h6D;
            MATCH_W'(6):  c = 8'h54;
            MATCH_W'(7):  c = 8'h69;
            MATCH_W'(8):  c = 8'h74;
            MATCH_W'(9):  c = 8'h6C;
            MATCH_W'(10): c = 8'h65;
            MATCH_W'(11): c = 8'h3D;
            default:      c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDERSCORE);
    endfunction

endpackage

// ===== hdl/icy_stream_title_extractor.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_stall  | command, data_byte, last_of_block, read_index
// output   | out_valid / out_stall| result_kind, title_found, title_start,
//          |                      | title_length, read_byte, overflowed
//
// Each transaction passes an input register; reads and block-ending appends then pass a result
// register. One transaction is accepted every cycle unless the input register is held by a stall.
// The title parser updates from one byte per cycle as appends leave the input register.
// A read returns the byte store's registered read port, taken as the read leaves that register.
// Reset clears the parser and both valid bits; the byte store is not cleared.
// A stalled result holds the input register only when it carries a result.
module icy_stream_title_extractor
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [7:0]                        data_byte,
    input  logic                              last_of_block,
    input  logic [11:0]                       read_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic                              title_found,
    output logic [icyst_pkg::TITLE_W-1:0]     title_start,
    output logic [icyst_pkg::TITLE_W-1:0]     title_length,
    output logic [7:0]                        read_byte,
    output logic                              overflowed
);

    logic        a_valid_reg, a_valid_next;
    logic        a_cmd_reg;
    logic [7:0]  a_byte_reg;
    logic        a_last_reg;
    logic [11:0] a_idx_reg;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg;
    logic                out_inrange_reg;
    icyst_pkg::summary_t out_sum_reg;

    logic                 accept;
    logic                 a_is_read;
    logic                 a_has_result;
    logic                 out_free;
    logic                 a_move;
    logic                 load_out;
    logic                 a_inrange;
    icyst_pkg::store_wr_t wr;
    icyst_pkg::summary_t  summary;
    logic [7:0]           rd_data;

    assign a_is_read    = (a_cmd_reg == icyst_pkg::CMD_READ);
    assign a_has_result = a_is_read || a_last_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign a_move       = a_valid_reg && (!a_has_result || out_free);
    assign load_out     = a_move && a_has_result;
    assign in_stall     = a_valid_reg && !a_move;
    assign accept       = in_valid && !in_stall;
    assign a_inrange    = (icyst_pkg::CNT_W'(a_idx_reg) < icyst_pkg::CNT_W'(icyst_pkg::MAX_BLOCK));

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_cmd_reg  <= command;
            a_byte_reg <= data_byte;
            a_last_reg <= last_of_block;
            a_idx_reg  <= read_index;
        end
        if (load_out)
        begin
            out_kind_reg    <= a_is_read;
            out_inrange_reg <= a_inrange;
            if (a_is_read)
            begin
                out_sum_reg <= '0;
            end
            else
            begin
                out_sum_reg <= summary;
            end
        end
    end

    icyst_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (a_move && !a_is_read),
        .data_byte     (a_byte_reg),
        .last_of_block (a_last_reg),
        .wr            (wr),
        .summary       (summary)
    );

    icyst_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (a_move && a_is_read),
        .rd_addr (icyst_pkg::ADDR_W'(a_idx_reg)),
        .rd_data (rd_data)
    );

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign title_found  = out_sum_reg.found;
    assign title_start  = out_sum_reg.start;
    assign title_length = out_sum_reg.length;
    assign overflowed   = out_sum_reg.overflowed;
    assign read_byte    = ((out_kind_reg == icyst_pkg::KIND_READ) && out_inrange_reg) ?
                          rd_data : 8'h00;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> a_valid_reg)
        else $error("input stalled with an empty input register");

    a_no_title_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !title_found) |-> ((title_start == '0) && (title_length == '0)))
        else $error("summary without a title carries an offset");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind) |-> (!title_found && !overflowed))
        else $error("read result carries summary fields");

    a_summary_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_kind) |-> (read_byte == 8'h00))
        else $error("summary carries read data");

endmodule

// ===== hdl/icyst_store.sv =====
module icyst_store
(
    input  logic                                clk,
    input  icyst_pkg::store_wr_t                wr,
    input  logic                                rd_en,
    input  logic [icyst_pkg::ADDR_W-1:0]        rd_addr,
    output logic [7:0]                          rd_data
);

    logic [7:0] mem [icyst_pkg::MAX_BLOCK];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/icyst_parser.sv =====
module icyst_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  last_of_block,
    output icyst_pkg::store_wr_t  wr,
    output icyst_pkg::summary_t   summary
);

    localparam int CW = icyst_pkg::CNT_W;
    localparam int MW = icyst_pkg::MATCH_W;

    icyst_pkg::phase_t phase_reg, phase_next;
    icyst_pkg::check_t chk_reg, chk_next;

    logic [CW-1:0] count_reg, count_next;
    logic [MW-1:0] match_reg, match_next;
    logic [CW-1:0] open_reg, open_next;
    logic          prevq_reg, prevq_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [CW-1:0] term_reg, term_next;
    logic          termf_reg, termf_next;
    logic [CW-1:0] nul_reg, nul_next;
    logic          nulf_reg, nulf_next;
    logic          qbn_reg, qbn_next;
    logic          ovf_reg, ovf_next;
    logic          title_reg, title_next;

    logic          full;
    logic          take;
    logic [CW-1:0] pos;
    logic [CW-1:0] end_pos;
    logic          drop_quote;
    logic [CW-1:0] len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= icyst_pkg::PH_KEY;
            chk_reg   <= icyst_pkg::CHK_IDLE;
            count_reg <= '0;
            match_reg <= '0;
            open_reg  <= '0;
            prevq_reg <= 1'b0;
            pend_reg  <= '0;
            term_reg  <= '0;
            termf_reg <= 1'b0;
            nul_reg   <= '0;
            nulf_reg  <= 1'b0;
            qbn_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            title_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            chk_reg   <= chk_next;
            count_reg <= count_next;
            match_reg <= match_next;
            open_reg  <= open_next;
            prevq_reg <= prevq_next;
            pend_reg  <= pend_next;
            term_reg  <= term_next;
            termf_reg <= termf_next;
            nul_reg   <= nul_next;
            nulf_reg  <= nulf_next;
            qbn_reg   <= qbn_next;
            ovf_reg   <= ovf_next;
            title_reg <= title_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        chk_next   = chk_reg;
        count_next = count_reg;
        match_next = match_reg;
        open_next  = open_reg;
        prevq_next = prevq_reg;
        pend_next  = pend_reg;
        term_next  = term_reg;
        termf_next = termf_reg;
        nul_next   = nul_reg;
        nulf_next  = nulf_reg;
        qbn_next   = qbn_reg;
        ovf_next   = ovf_reg;
        title_next = title_reg;

        full = (count_reg == CW'(icyst_pkg::MAX_BLOCK));
        take = step && !full;
        pos  = count_reg;

        if (step && full)
        begin
            ovf_next = 1'b1;
        end

        if (take)
        begin
            count_next = count_reg + CW'(1);
            unique case (phase_reg)
                icyst_pkg::PH_KEY:
                begin
                    if (data_byte == icyst_pkg::key_char(match_reg))
                    begin
                        if (match_reg == MW'(icyst_pkg::KEY_LEN - 1))
                        begin
                            phase_next = icyst_pkg::PH_OPEN;
                            match_next = '0;
                        end
                        else
                        begin
                            match_next = match_reg + MW'(1);
                        end
                    end
                    else if (data_byte == icyst_pkg::key_char(MW'(0)))
                    begin
                        match_next = MW'(1);
                    end
                    else
                    begin
                        match_next = '0;
                    end
                end
                icyst_pkg::PH_OPEN:
                begin
                    if (data_byte == icyst_pkg::CH_QUOTE)
                    begin
                        phase_next = icyst_pkg::PH_TITLE;
                        title_next = 1'b1;
                        open_next  = pos + CW'(1);
                        prevq_next = 1'b0;
                        chk_next   = icyst_pkg::CHK_IDLE;
                    end
                    else
                    begin
                        phase_next = icyst_pkg::PH_STOP;
                    end
                end
                icyst_pkg::PH_TITLE:
                begin
                    if (!nulf_reg && (data_byte == icyst_pkg::CH_NUL))
                    begin
                        nulf_next = 1'b1;
                        nul_next  = pos;
                        qbn_next  = prevq_reg;
                    end
                    prevq_next = (data_byte == icyst_pkg::CH_QUOTE);
                    unique case (chk_reg)
                        icyst_pkg::CHK_IDLE:
                        begin
                            if (prevq_reg && (data_byte == icyst_pkg::CH_SEMI))
                            begin
                                chk_next  = icyst_pkg::CHK_FIRST;
                                pend_next = pos - CW'(1);
                            end
                        end
                        icyst_pkg::CHK_FIRST:
                        begin
                            if (data_byte == icyst_pkg::CH_NUL)
                            begin
                                termf_next = 1'b1;
                                term_next  = pend_reg;
                                phase_next = icyst_pkg::PH_STOP;
                                chk_next   = icyst_pkg::CHK_IDLE;
                            end
                            else if (icyst_pkg::is_letter(data_byte))
                            begin
                                chk_next = icyst_pkg::CHK_WORD;
                            end
                            else
                            begin
                                chk_next = icyst_pkg::CHK_IDLE;
                            end
                        end
                        icyst_pkg::CHK_WORD:
                        begin
                            if (data_byte == icyst_pkg::CH_EQUAL)
                            begin
                                chk_next = icyst_pkg::CHK_EQ;
                            end
                            else if (!icyst_pkg::is_word(data_byte))
                            begin
                                chk_next = icyst_pkg::CHK_IDLE;
                            end
                        end
                        icyst_pkg::CHK_EQ:
                        begin
                            if (data_byte == icyst_pkg::CH_QUOTE)
                            begin
                                termf_next = 1'b1;
                                term_next  = pend_reg;
                                phase_next = icyst_pkg::PH_STOP;
                            end
                            chk_next = icyst_pkg::CHK_IDLE;
                        end
                        default:
                        begin
                            chk_next = icyst_pkg::CHK_IDLE;
                        end
                    endcase
                end
                icyst_pkg::PH_STOP:
                begin
                    phase_next = icyst_pkg::PH_STOP;
                end
                default:
                begin
                    phase_next = icyst_pkg::PH_STOP;
                end
            endcase
        end

        // A candidate still waiting for its first following byte ends the title before its quote.
        drop_quote = 1'b0;
        if (termf_next)
        begin
            end_pos = term_next;
        end
        else if (chk_next == icyst_pkg::CHK_FIRST)
        begin
            end_pos = pend_next;
        end
        else
        begin
            end_pos    = nulf_next ? nul_next : count_next;
            drop_quote = nulf_next ? qbn_next : prevq_next;
        end
        len = end_pos - open_next - CW'(drop_quote);

        summary.found      = title_next;
        summary.start      = title_next ? icyst_pkg::TITLE_W'(open_next) : '0;
        summary.length     = title_next ? icyst_pkg::TITLE_W'(len) : '0;
        summary.overflowed = ovf_next;

        if (step && last_of_block)
        begin
            phase_next = icyst_pkg::PH_KEY;
            chk_next   = icyst_pkg::CHK_IDLE;
            count_next = '0;
            match_next = '0;
            prevq_next = 1'b0;
            termf_next = 1'b0;
            nulf_next  = 1'b0;
            qbn_next   = 1'b0;
            ovf_next   = 1'b0;
            title_next = 1'b0;
        end
    end

    assign wr.en   = take;
    assign wr.addr = pos[icyst_pkg::ADDR_W-1:0];
    assign wr.data = data_byte;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(icyst_pkg::MAX_BLOCK))
        else $error("held byte count passed the store capacity");

    a_check_in_title: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_reg != icyst_pkg::CHK_IDLE) |-> (phase_reg == icyst_pkg::PH_TITLE))
        else $error("terminator check active outside the title");

endmodule
